FILE: design/itg_pkg.sv
//------------------------------------------------------------------------------
// itg_pkg
// Shared types, constants and the CORDIC angle table for the tilt and gyro
// integration block.
//------------------------------------------------------------------------------
package itg_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int ANGLE_TABLE_LEN  = 24;

    // Datapath widths. Corrected axes fit 17 bits, the CORDIC value is
    // 17 bits times 256 plus growth.
    localparam int CW  = 17;
    localparam int XYW = 29;
    localparam int ZW  = 26;

    localparam logic signed [15:0] OFFSET_X_RST = 16'sd122;
    localparam logic signed [15:0] OFFSET_Y_RST = -16'sd8;
    localparam logic signed [15:0] OFFSET_Z_RST = 16'sd3123;

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * 65536);
    localparam logic signed [15:0]   TILT_LIMIT = 16'sd23040;

    localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

    typedef logic signed [CW-1:0] axis_t;

    // One vector handed from cell to cell.
    typedef struct packed {
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [ZW-1:0]  z;
        logic                  zero;
    } cvec_t;

    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                0: r = ZW'(2949120);  1: r = ZW'(1740967);
                2: r = ZW'(919879);   3: r = ZW'(466945);
                4: r = ZW'(234379);   5: r = ZW'(117304);
                6: r = ZW'(58666);    7: r = ZW'(29335);
                8: r = ZW'(14668);    9: r = ZW'(7334);
                10: r = ZW'(3667);    11: r = ZW'(1833);
                12: r = ZW'(917);     13: r = ZW'(458);
                14: r = ZW'(229);     15: r = ZW'(115);
                16: r = ZW'(57);      17: r = ZW'(29);
                18: r = ZW'(14);      19: r = ZW'(7);
                20: r = ZW'(4);       21: r = ZW'(2);
                22: r = ZW'(1);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: design/imu_tilt_and_gyro_integrate_top.sv
//------------------------------------------------------------------------------
// imu_tilt_and_gyro_integrate_top
// Accelerometer tilt angles by CORDIC and saturating gyro integration.
//------------------------------------------------------------------------------
// Usage: an input item (accel_x/y/z, rate_x/y/z, time_ms) is taken when
// in_valid is high and in_stall is low. One result item appears on the output
// channel per input item and is held until out_stall is low while out_valid
// is high. The offsets are written through cfg_valid/cfg_ready with cfg_index
// 0..2; other indexes are ignored.
// The three angles share one row of NST registered cells (CORDIC_STEPS, at most
// ANGLE_TABLE_LEN), one cell per iteration. The roll angle runs first; the two
// magnitudes come from a bit-serial square root unit that feeds the pitch and
// yaw passes. After the item is accepted the block forms the gyro products,
// runs the roll pass, a root, the pitch pass, a root and the yaw pass, then
// saturates the accumulators. The block takes one item at a time; in_stall is
// high while an item is in work or its result is not taken. The next item can
// be accepted from the cycle after the result is taken.
// Reset clears the timestamp and the three accumulators and loads the
// default offsets. A stalled result simply waits in the output registers.
//------------------------------------------------------------------------------
module imu_tilt_and_gyro_integrate_top
    import itg_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  accel_x,
    input  logic signed [15:0]  accel_y,
    input  logic signed [15:0]  accel_z,
    input  logic signed [15:0]  rate_x,
    input  logic signed [15:0]  rate_y,
    input  logic signed [15:0]  rate_z,
    input  logic [31:0]         time_ms,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [16:0]  corrected_x,
    output logic signed [16:0]  corrected_y,
    output logic signed [16:0]  corrected_z,
    output logic signed [15:0]  roll_tilt,
    output logic signed [15:0]  pitch_tilt,
    output logic signed [15:0]  yaw_tilt,
    output logic signed [47:0]  roll_integral,
    output logic signed [47:0]  pitch_integral,
    output logic signed [47:0]  yaw_integral
);
    localparam int NST = (CORDIC_STEPS < ANGLE_TABLE_LEN) ? CORDIC_STEPS
                                                            : ANGLE_TABLE_LEN;
    localparam int CNTW = $clog2(NST + 2);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INT   = 9'b000000010,
        S_ROLL  = 9'b000000100,
        S_MAG1  = 9'b000001000,
        S_PITCH = 9'b000010000,
        S_MAG2  = 9'b000100000,
        S_YAW   = 9'b001000000,
        S_SAT   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] offx_reg, offy_reg, offz_reg;
    logic [31:0]        last_reg;
    logic signed [47:0] rsum_reg, psum_reg, ysum_reg;
    axis_t              cx_reg, cy_reg, cz_reg;
    logic signed [15:0] rx_reg, ry_reg, rz_reg;
    logic [31:0]        dt_reg;
    logic signed [48:0] prod_reg [3];
    logic [1:0]         ax_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic signed [15:0] roll_reg, pitch_reg, yaw_reg;
    logic [17:0]        mag_reg;

    cvec_t chain [NST+1];
    cvec_t seed;
    logic signed [CW-1:0] sa;
    logic signed [17:0]   sbm;
    logic                 sq_start, sq_done;
    logic [17:0]          sq_root;
    logic [34:0]          sq_n;
    logic signed [33:0]   sqa, sqb;

    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_cell
            itg_cordic_cell #(.STEP(g)) u_cell (
                .clk  (clk),
                .din  (chain[g]),
                .dout (chain[g+1])
            );
        end
    endgenerate

    // Operands of the current CORDIC pass (y, x).
    always_comb
    begin
        case (state_reg)
            S_PITCH:
            begin
                sa  = -cx_reg;
                sbm = {1'b0, mag_reg[16:0]};
            end
            S_YAW:
            begin
                sa  = cz_reg;
                sbm = {1'b0, mag_reg[16:0]};
            end
            default:
            begin
                sa  = cy_reg;
                sbm = 18'(cz_reg);
            end
        endcase
    end

    logic signed [XYW-1:0] sx, sy;
    always_comb
    begin
        sx = XYW'(sbm) <<< 8;
        sy = XYW'(sa) <<< 8;
        seed.zero = (sa == 0) && (sbm == 0);
        seed.z = '0;
        seed.x = sx;
        seed.y = sy;
        if (sbm[17])
        begin
            seed.x = -sx;
            seed.y = -sy;
            seed.z = sa[CW-1] ? -HALF_TURN : HALF_TURN;
        end
    end
    assign chain[0] = seed;

    logic signed [ZW-1:0] zr;
    logic signed [ZW-10:0] zs;
    logic signed [15:0]    ang;
    always_comb
    begin
        zr = chain[NST].z + ZW'(256);
        zs = zr[ZW-1:9];
        if (chain[NST].zero)
            ang = '0;
        else if (zs > (ZW-9)'(TILT_LIMIT))
            ang = TILT_LIMIT;
        else if (zs < -((ZW-9)'(TILT_LIMIT)))
            ang = -TILT_LIMIT;
        else
            ang = 16'(zs);
    end

    assign sqa  = (state_reg == S_MAG2) ? cx_reg * cx_reg : cy_reg * cy_reg;
    assign sqb  = (state_reg == S_MAG2) ? cy_reg * cy_reg : cz_reg * cz_reg;
    assign sq_n = 35'(sqa) + 35'(sqb);
    assign sq_start = ((state_reg == S_MAG1) || (state_reg == S_MAG2))
                      && (cnt_reg == '0);

    itg_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .n     (sq_n),
        .done  (sq_done),
        .root  (sq_root)
    );

    logic accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    logic pass_end;
    assign pass_end = (cnt_reg == CNTW'(NST));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_INT;
            S_INT:   if (ax_reg == 2'd2) state_next = S_ROLL;
            S_ROLL:  if (pass_end) state_next = S_MAG1;
            S_MAG1:  if (sq_done) state_next = S_PITCH;
            S_PITCH: if (pass_end) state_next = S_MAG2;
            S_MAG2:  if (sq_done) state_next = S_YAW;
            S_YAW:   if (pass_end) state_next = S_SAT;
            S_SAT:   if (ax_reg == 2'd2) state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // The accumulator being saturated this cycle.
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_sat;
    always_comb
    begin
        case (ax_reg)
            2'd0:    acc_sum = 49'(rsum_reg) + prod_reg[0];
            2'd1:    acc_sum = 49'(psum_reg) + prod_reg[1];
            default: acc_sum = 49'(ysum_reg) + prod_reg[2];
        endcase
        if (acc_sum > 49'(SUM_MAX))
            acc_sat = SUM_MAX;
        else if (acc_sum < 49'(SUM_MIN))
            acc_sat = SUM_MIN;
        else
            acc_sat = acc_sum[47:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            offx_reg  <= OFFSET_X_RST;
            offy_reg  <= OFFSET_Y_RST;
            offz_reg  <= OFFSET_Z_RST;
            last_reg  <= '0;
            rsum_reg  <= '0;
            psum_reg  <= '0;
            ysum_reg  <= '0;
            ax_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OFFSET_X: offx_reg <= cfg_data;
                    REG_OFFSET_Y: offy_reg <= cfg_data;
                    REG_OFFSET_Z: offz_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
                last_reg <= time_ms;
            if (state_reg == S_SAT)
            begin
                case (ax_reg)
                    2'd0:    rsum_reg <= acc_sat;
                    2'd1:    psum_reg <= acc_sat;
                    default: ysum_reg <= acc_sat;
                endcase
            end
            if ((state_reg == S_INT || state_reg == S_SAT) && ax_reg != 2'd2)
                ax_reg <= ax_reg + 2'd1;
            else
                ax_reg <= '0;
            if (state_reg == S_ROLL || state_reg == S_PITCH || state_reg == S_YAW)
                cnt_reg <= pass_end ? '0 : cnt_reg + CNTW'(1);
            else if (state_reg == S_MAG1 || state_reg == S_MAG2)
                cnt_reg <= sq_done ? '0 : CNTW'(1);
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg <= CW'(accel_x) - CW'(offx_reg);
            cy_reg <= CW'(accel_y) - CW'(offy_reg);
            cz_reg <= CW'(accel_z) - CW'(offz_reg);
            rx_reg <= rate_x;
            ry_reg <= rate_y;
            rz_reg <= rate_z;
            dt_reg <= time_ms - last_reg;
        end
        if (state_reg == S_INT)
        begin
            case (ax_reg)
                2'd0:    prod_reg[0] <= 49'(rx_reg) * 49'($signed({1'b0, dt_reg}));
                2'd1:    prod_reg[1] <= 49'(ry_reg) * 49'($signed({1'b0, dt_reg}));
                default: prod_reg[2] <= 49'(rz_reg) * 49'($signed({1'b0, dt_reg}));
            endcase
        end
        if (sq_done)
            mag_reg <= sq_root;
        if (pass_end)
        begin
            case (state_reg)
                S_ROLL:  roll_reg  <= ang;
                S_PITCH: pitch_reg <= ang;
                default: yaw_reg   <= ang;
            endcase
        end
    end

    assign corrected_x    = cx_reg;
    assign corrected_y    = cy_reg;
    assign corrected_z    = cz_reg;
    assign roll_tilt      = roll_reg;
    assign pitch_tilt     = pitch_reg;
    assign yaw_tilt       = yaw_reg;
    assign roll_integral  = rsum_reg;
    assign pitch_integral = psum_reg;
    assign yaw_integral   = ysum_reg;
endmodule

FILE: design/itg_cordic_cell.sv
//------------------------------------------------------------------------------
// itg_cordic_cell
// One registered CORDIC vectoring step with a fixed shift.
//------------------------------------------------------------------------------
module itg_cordic_cell
    import itg_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  clk,
    input  cvec_t din,
    output cvec_t dout
);
    localparam int SH = (STEP < XYW) ? STEP : XYW - 1;
    cvec_t v_next;

    always_comb
    begin
        v_next = din;
        if (!din.y[XYW-1])
        begin
            v_next.x = din.x + (din.y >>> SH);
            v_next.y = din.y - (din.x >>> SH);
            v_next.z = din.z + atan_deg(STEP);
        end
        else
        begin
            v_next.x = din.x - (din.y >>> SH);
            v_next.y = din.y + (din.x >>> SH);
            v_next.z = din.z - atan_deg(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        dout <= v_next;
    end
endmodule

FILE: design/itg_isqrt.sv
//------------------------------------------------------------------------------
// itg_isqrt
// Bit-serial integer square root of a 35-bit sum of squares, one bit a cycle.
//------------------------------------------------------------------------------
module itg_isqrt
    import itg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [34:0] n,
    output logic        done,
    output logic [17:0] root
);
    logic [35:0] rem_reg, rem_next;
    logic [17:0] root_reg, root_next;
    logic [35:0] n_reg, n_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [37:0] trial;
    logic [37:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        n_next    = n_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, n_reg[35:34]};
        trial     = {18'd0, root_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            root_next = '0;
            n_next    = {1'b0, n};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[33:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = 36'(shifted - trial);
                root_next = {root_reg[16:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[35:0];
                root_next = {root_reg[16:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd17)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        n_reg    <= n_next;
    end

    assign done = busy_reg && (cnt_reg == 5'd17);
    assign root = root_next;
endmodule

FILE: design/itg_checker.sv
//------------------------------------------------------------------------------
// itg_port_props
// Port-level checks of the tilt and gyro integration block.
//------------------------------------------------------------------------------
module itg_port_props
    import itg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] roll_tilt,
    input logic signed [15:0] pitch_tilt,
    input logic               cfg_ready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(roll_tilt))
        else $error("result changed while stalled");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result appeared without work");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_tilt <= TILT_LIMIT && roll_tilt >= -TILT_LIMIT
                       && pitch_tilt <= TILT_LIMIT && pitch_tilt >= -TILT_LIMIT))
        else $error("angle out of range");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall && !cfg_ready)
        else $error("input open while result pending");
endmodule

bind imu_tilt_and_gyro_integrate_top itg_port_props u_itg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .roll_tilt  (roll_tilt),
    .pitch_tilt (pitch_tilt),
    .cfg_ready  (cfg_ready)
);

FILE: sim/itg_checker.sv
//------------------------------------------------------------------------------
// itg_checker
// Watches the sample, offset and result channels of the tilt and gyro block.
// It keeps its own offsets, timestamp and accumulators and predicts each
// result item. Every result is then compared field by field with the oldest
// prediction still waiting.
//------------------------------------------------------------------------------
module itg_checker
    import itg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic signed [15:0]  accel_x,
    input  logic signed [15:0]  accel_y,
    input  logic signed [15:0]  accel_z,
    input  logic signed [15:0]  rate_x,
    input  logic signed [15:0]  rate_y,
    input  logic signed [15:0]  rate_z,
    input  logic [31:0]         time_ms,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic signed [16:0]  corrected_x,
    input  logic signed [16:0]  corrected_y,
    input  logic signed [16:0]  corrected_z,
    input  logic signed [15:0]  roll_tilt,
    input  logic signed [15:0]  pitch_tilt,
    input  logic signed [15:0]  yaw_tilt,
    input  logic signed [47:0]  roll_integral,
    input  logic signed [47:0]  pitch_integral,
    input  logic signed [47:0]  yaw_integral,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STEPS     = DEF_CORDIC_STEPS;
    localparam longint TILT_MAX  = 23040;
    localparam longint ACC_MAX   = 64'sd140737488355327;
    localparam longint ACC_MIN   = -64'sd140737488355328;

    // atan(2^-i) in degrees, 16 fraction bits.
    localparam longint ARCTAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [16:0] cx;
        logic signed [16:0] cy;
        logic signed [16:0] cz;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [47:0] roll_acc;
        logic signed [47:0] pitch_acc;
        logic signed [47:0] yaw_acc;
    } tilt_result_t;

    tilt_result_t       expected_q[$];
    logic signed [15:0] offs_x, offs_y, offs_z;
    logic [31:0]        prev_time;
    longint             acc_roll, acc_pitch, acc_yaw;
    int                 mismatches;

    assign pending = expected_q.size();

    function automatic longint root_floor(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 40;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC on (x, y) scaled by 256; the result is atan2(y, x), limited to +-TILT_MAX.
    function automatic longint tilt_angle(longint y, longint x);
        longint ang;
        longint dx;
        longint dy;
        if (x == 0 && y == 0)
            return 0;
        ang = 0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                ang = ang + ARCTAN_DEG[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                ang = ang - ARCTAN_DEG[i];
            end
        end
        ang = (ang + 256) >>> 9;
        if (ang > TILT_MAX)
            ang = TILT_MAX;
        if (ang < -TILT_MAX)
            ang = -TILT_MAX;
        return ang;
    endfunction

    function automatic longint sat_add(longint acc, longint rate, longint dt);
        longint s;
        s = acc + rate * dt;
        if (s > ACC_MAX)
            s = ACC_MAX;
        if (s < ACC_MIN)
            s = ACC_MIN;
        return s;
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            fail_count++;
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch %s: expected %0d, got %0d",
                         $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tilt_result_t r;
        longint       cx, cy, cz, dt;
        if (!rst_n)
        begin
            offs_x     <= OFFSET_X_RST;
            offs_y     <= OFFSET_Y_RST;
            offs_z     <= OFFSET_Z_RST;
            prev_time  <= '0;
            acc_roll   = 0;
            acc_pitch  = 0;
            acc_yaw    = 0;
            fail_count = 0;
            mismatches = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OFFSET_X: offs_x <= cfg_data;
                    REG_OFFSET_Y: offs_y <= cfg_data;
                    REG_OFFSET_Z: offs_z <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                cx = longint'(accel_x) - longint'(offs_x);
                cy = longint'(accel_y) - longint'(offs_y);
                cz = longint'(accel_z) - longint'(offs_z);
                dt = longint'(32'(time_ms - prev_time));
                prev_time <= time_ms;
                acc_roll  = sat_add(acc_roll, rate_x, dt);
                acc_pitch = sat_add(acc_pitch, rate_y, dt);
                acc_yaw   = sat_add(acc_yaw, rate_z, dt);
                r.cx        = 17'(cx);
                r.cy        = 17'(cy);
                r.cz        = 17'(cz);
                r.roll      = 16'(tilt_angle(cy, cz));
                r.pitch     = 16'(tilt_angle(-cx, root_floor(cy * cy + cz * cz)));
                r.yaw       = 16'(tilt_angle(cz, root_floor(cx * cx + cy * cy)));
                r.roll_acc  = 48'(acc_roll);
                r.pitch_acc = 48'(acc_pitch);
                r.yaw_acc   = 48'(acc_yaw);
                expected_q.push_back(r);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t result item with no sample pending", $time);
                end
                else
                begin
                    r = expected_q.pop_front();
                    check_field("corrected_x", r.cx, corrected_x);
                    check_field("corrected_y", r.cy, corrected_y);
                    check_field("corrected_z", r.cz, corrected_z);
                    check_field("roll_tilt", r.roll, roll_tilt);
                    check_field("pitch_tilt", r.pitch, pitch_tilt);
                    check_field("yaw_tilt", r.yaw, yaw_tilt);
                    check_field("roll_integral", r.roll_acc, roll_integral);
                    check_field("pitch_integral", r.pitch_acc, pitch_integral);
                    check_field("yaw_integral", r.yaw_acc, yaw_integral);
                end
            end
        end
    end

endmodule

FILE: sim/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Drives the tilt and gyro block with directed and random samples and offset
// writes under several idle and stall patterns. The checker beside the block
// predicts and compares every result item; this module gives the verdict.
//------------------------------------------------------------------------------
module tb_top;
    import itg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic signed [15:0]  accel_x = '0, accel_y = '0, accel_z = '0;
    logic signed [15:0]  rate_x = '0, rate_y = '0, rate_z = '0;
    logic [31:0]         time_ms = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [15:0]         cfg_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [16:0]  corrected_x, corrected_y, corrected_z;
    logic signed [15:0]  roll_tilt, pitch_tilt, yaw_tilt;
    logic signed [47:0]  roll_integral, pitch_integral, yaw_integral;
    int                  fail_count;
    int                  pending;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    logic [31:0]         clock_ms = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    imu_tilt_and_gyro_integrate_top i_dut (.*);

    itg_checker i_checker (.*);

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic send_sample(input logic signed [15:0] ax, ay, az, rx, ry, rz,
                               input logic [31:0] ts);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= ax;
        accel_y  <= ay;
        accel_z  <= az;
        rate_x   <= rx;
        rate_y   <= ry;
        rate_z   <= rz;
        time_ms  <= ts;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Offsets change only once every pending result has come out.
    task automatic write_offset(input logic [1:0] idx, input logic [15:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Offsets as last written, tracked here so samples can cancel them.
    logic signed [15:0] cur_offs [3] = '{OFFSET_X_RST, OFFSET_Y_RST, OFFSET_Z_RST};

    function automatic logic signed [15:0] i_checker_offs(int i);
        return cur_offs[i];
    endfunction

    task automatic random_sample();
        logic signed [15:0] ax, ay, az;
        int                 pick;
        pick = $urandom_range(9);
        ax = 16'($urandom);
        ay = 16'($urandom);
        az = 16'($urandom);
        if (pick == 0)
        begin
            // Corrected vector near zero, including the all-zero case.
            ax = 16'(int'(i_checker_offs(0)) + int'($urandom_range(2)) - 1);
            ay = 16'(int'(i_checker_offs(1)) + int'($urandom_range(2)) - 1);
            az = 16'(int'(i_checker_offs(2)) + int'($urandom_range(2)) - 1);
        end
        else if (pick < 4)
        begin
            ax = 16'(int'($urandom_range(4095)) - 2048);
            ay = 16'(int'($urandom_range(4095)) - 2048);
            az = 16'(int'($urandom_range(4095)) - 2048);
        end
        if ($urandom_range(19) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(40);
        send_sample(ax, ay, az, 16'($urandom), 16'($urandom), 16'($urandom), clock_ms);
    endtask

    task automatic set_offsets(input logic signed [15:0] ox, oy, oz);
        write_offset(REG_OFFSET_X, ox);
        write_offset(REG_OFFSET_Y, oy);
        write_offset(REG_OFFSET_Z, oz);
        cur_offs = '{ox, oy, oz};
    endtask

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First sample measures time from zero; then extremes and wrap.
        send_sample(16'sd122, -16'sd8, 16'sd3123, 16'sd1, -16'sd1, 16'sd0, 32'd5);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767,
                    16'sd32767, -16'sd32768, 16'sd1, 32'hFFFF_FFFF);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768,
                    16'sd32767, -16'sd32768, -16'sd1, 32'hFFFF_FFFE);
        send_sample(16'sd0, 16'sd100, -16'sd5000, 16'sd0, 16'sd0, 16'sd0, 32'd10);
        send_sample(16'sd0, -16'sd100, -16'sd5000, -16'sd32768, 16'sd32767,
                    16'sd0, 32'd9);
        send_sample(16'sd122, -16'sd8, -16'sd32768, 16'sd5, 16'sd5, 16'sd5, 32'd20);
        send_sample(16'sd122, 16'sd32767, 16'sd3123, 16'sd0, 16'sd0, 16'sd0, 32'd20);
        send_sample(-16'sd32768, -16'sd8, 16'sd3123, 16'sd0, 16'sd0, 16'sd0, 32'd21);
        send_sample(16'sd32767, -16'sd8, 16'sd3123, 16'sd0, 16'sd0, 16'sd0, 32'd22);
        send_sample(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                    16'shAAAA, 32'hAAAA_AAAA);
        send_sample(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                    16'sh5555, 32'h5555_5555);

        // Extreme offsets and an ignored register index.
        set_offsets(-16'sd32768, 16'sd32767, 16'sd0);
        write_offset(2'd3, 16'h1234);
        send_sample(16'sd32767, -16'sd32768, 16'sd0, 16'sd1, 16'sd1, 16'sd1, 32'd100);
        send_sample(-16'sd32768, 16'sd32767, -16'sd1, 16'sd1, 16'sd1, 16'sd1, 32'd101);
        set_offsets(16'sd32767, -16'sd32768, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd1, 16'sd1, 16'sd1, 32'd102);
        send_sample(16'sd32767, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 32'd103);
        clock_ms = 32'd103;

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (ph == 0)
                set_offsets(OFFSET_X_RST, OFFSET_Y_RST, OFFSET_Z_RST);
            else
                set_offsets(16'($urandom), 16'($urandom), 16'($urandom));
            for (int n = 0; n < 485; n++)
                random_sample();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
